### design/pdid_pkg.sv
// Shared types and constants for the pack delta instruction decoder.
// Used by pack_delta_instruction_decoder_unit; no dependencies.
package pdid_pkg;

  localparam int unsigned LEN_W     = 22;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OUT_DEPTH_DEFAULT = 4;

  localparam logic [LEN_W-1:0] LIMIT_DEFAULT  = LEN_W'(3 * 1024 * 1024);
  localparam logic [23:0]      COPY_SIZE_ZERO = 24'h010000;
  localparam logic [3:0]       VARINT_CHUNKS  = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    CMD_COPY     = 2'd0,
    CMD_LITERAL  = 2'd1,
    CMD_FINISHED = 2'd2,
    CMD_ERROR    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SRC_MISMATCH = 3'd1,
    ST_TGT_BIG      = 3'd2,
    ST_TRUNCATED    = 3'd3,
    ST_RESERVED_OP  = 3'd4,
    ST_COPY_RANGE   = 3'd5,
    ST_LEN_MISMATCH = 3'd6
  } status_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] copy_offset;
    logic [23:0] copy_length;
    logic [7:0]  literal_value;
    status_t     status;
    logic        end_of_run;
  } res_t;

endpackage

### design/pack_delta_instruction_decoder_unit.sv
// Pack delta instruction decoder: header varints, copy/literal opcodes, closing status.
// Depends on pdid_pkg (types, status codes, constants).

// Usage:
//  - in_*: one delta byte per request, in_final_byte marks the last byte of a stream.
//  - out_*: command results (copy, literal, finished, error) in stream order.
//  - cfg_*: writes base_length (index 0) and target_limit (index 1); always ready.
//    Write only while the block is idle.
// Each accepted byte updates the decoder state in the same cycle and pushes zero,
// one or two results into an output queue of OUT_DEPTH entries. Each result is
// registered in the queue and offered on out_* from there. One byte is taken
// per cycle while the receiver keeps up and every byte yields at most one result;
// a byte that yields two (a copy or literal on the final byte) fills two entries.
// in_ready is high while the queue has room for two results, so a stalled
// receiver fills the queue and then holds off the input.
// Reset clears stream state, the queue and sets base_length to 0 and
// target_limit to 3145728. After each final byte the stream state returns to
// its reset value; configuration is kept.
module pack_delta_instruction_decoder_unit #(
  parameter int unsigned OUT_DEPTH = pdid_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_delta_byte,
  input  logic                           in_final_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_command,
  output logic [31:0]                    out_copy_offset,
  output logic [23:0]                    out_copy_length,
  output logic [7:0]                     out_literal_value,
  output logic [2:0]                     out_status,
  output logic                           out_end_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pdid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdid_pkg::LEN_W-1:0]     cfg_wdata
);
  import pdid_pkg::*;

  localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(OUT_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ROOM2 = CNT_W'(OUT_DEPTH - 2);

  typedef enum logic [2:0] {
    PH_SRC  = 3'd0,
    PH_DST  = 3'd1,
    PH_OP   = 3'd2,
    PH_COPY = 3'd3,
    PH_LIT  = 3'd4
  } phase_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [LEN_W-1:0] base_len_r, tgt_limit_r;

  // stream state
  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] src_lo_r, src_lo_nxt, tgt_lo_r, tgt_lo_nxt;
  logic             src_hi_r, src_hi_nxt, tgt_hi_r, tgt_hi_nxt;
  logic [3:0]       vcnt_r, vcnt_nxt;
  logic [6:0]       pend_r, pend_nxt;
  logic [31:0]      goff_r, goff_nxt;
  logic [23:0]      gsize_r, gsize_nxt;
  logic [6:0]       lit_left_r, lit_left_nxt;
  logic [LEN_W-1:0] prod_r, prod_nxt;
  logic             over_r, over_nxt;
  logic             failed_r, failed_nxt;
  status_t          fstat_r, fstat_nxt;

  // output queue
  res_t             q_mem [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             in_acc, out_acc;
  logic             r0_vld, r1_vld;
  res_t             r0, r1;
  status_t          err;

  // working signals
  logic [LEN_W-1:0] v_lo;
  logic             v_hi;
  logic [6:0]       v_d;
  logic [6:0]       sel;
  logic             do_finish;
  logic [31:0]      f_off;
  logic [23:0]      f_raw, f_size;
  logic [32:0]      f_end;
  logic             add_en;
  logic [23:0]      add_amt;
  logic [24:0]      prod_sum;
  logic             src_eq, tgt_big;

  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign in_ready  = (count_r <= CNT_ROOM2);
  assign out_valid = (count_r != '0);
  assign cfg_ready = 1'b1;

  // varint chunk merge, shared by both header fields
  always_comb begin
    v_lo = (phase_r == PH_SRC) ? src_lo_r : tgt_lo_r;
    v_hi = (phase_r == PH_SRC) ? src_hi_r : tgt_hi_r;
    v_d  = in_delta_byte[6:0];
    case (vcnt_r)
      4'd0: v_lo[6:0]   = v_lo[6:0] | v_d;
      4'd1: v_lo[13:7]  = v_lo[13:7] | v_d;
      4'd2: v_lo[20:14] = v_lo[20:14] | v_d;
      4'd3: begin
        v_lo[21] = v_lo[21] | v_d[0];
        v_hi     = v_hi | (|v_d[6:1]);
      end
      4'd4, 4'd5, 4'd6, 4'd7, 4'd8: v_hi = v_hi | (|v_d);
      4'd9: v_hi = v_hi | v_d[0];
      default: ;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    src_lo_nxt   = src_lo_r;
    src_hi_nxt   = src_hi_r;
    tgt_lo_nxt   = tgt_lo_r;
    tgt_hi_nxt   = tgt_hi_r;
    vcnt_nxt     = vcnt_r;
    pend_nxt     = pend_r;
    goff_nxt     = goff_r;
    gsize_nxt    = gsize_r;
    lit_left_nxt = lit_left_r;
    failed_nxt   = failed_r;
    fstat_nxt    = fstat_r;
    err          = ST_OK;
    do_finish    = 1'b0;
    add_en       = 1'b0;
    add_amt      = 24'd1;
    r0_vld       = 1'b0;
    r1_vld       = 1'b0;
    r0           = '0;
    r1           = '0;
    sel          = pend_r & (~pend_r + 7'd1);

    if (failed_r) begin
      if (in_final_byte) begin
        r1_vld        = 1'b1;
        r1.command    = CMD_ERROR;
        r1.status     = fstat_r;
        r1.end_of_run = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_SRC: begin
          src_lo_nxt = v_lo;
          src_hi_nxt = v_hi;
          vcnt_nxt   = (vcnt_r == VARINT_CHUNKS) ? vcnt_r : vcnt_r + 4'd1;
          if (!in_delta_byte[7]) begin
            phase_nxt = PH_DST;
            vcnt_nxt  = '0;
            if (v_hi || (v_lo != base_len_r)) err = ST_SRC_MISMATCH;
          end
        end
        PH_DST: begin
          tgt_lo_nxt = v_lo;
          tgt_hi_nxt = v_hi;
          vcnt_nxt   = (vcnt_r == VARINT_CHUNKS) ? vcnt_r : vcnt_r + 4'd1;
          if (!in_delta_byte[7]) begin
            phase_nxt = PH_OP;
            vcnt_nxt  = '0;
            if (v_hi || (v_lo > tgt_limit_r)) err = ST_TGT_BIG;
          end
        end
        PH_OP: begin
          if (in_delta_byte[7]) begin
            goff_nxt  = '0;
            gsize_nxt = '0;
            pend_nxt  = in_delta_byte[6:0];
            if (in_delta_byte[6:0] == 7'd0) do_finish = 1'b1;
            else phase_nxt = PH_COPY;
          end else if (in_delta_byte != 8'd0) begin
            lit_left_nxt = in_delta_byte[6:0];
            phase_nxt    = PH_LIT;
          end else begin
            err = ST_RESERVED_OP;
          end
        end
        PH_COPY: begin
          if (sel[0]) goff_nxt[7:0]    = goff_r[7:0] | in_delta_byte;
          if (sel[1]) goff_nxt[15:8]   = goff_r[15:8] | in_delta_byte;
          if (sel[2]) goff_nxt[23:16]  = goff_r[23:16] | in_delta_byte;
          if (sel[3]) goff_nxt[31:24]  = goff_r[31:24] | in_delta_byte;
          if (sel[4]) gsize_nxt[7:0]   = gsize_r[7:0] | in_delta_byte;
          if (sel[5]) gsize_nxt[15:8]  = gsize_r[15:8] | in_delta_byte;
          if (sel[6]) gsize_nxt[23:16] = gsize_r[23:16] | in_delta_byte;
          pend_nxt = pend_r & (pend_r - 7'd1);
          if (pend_nxt == 7'd0) do_finish = 1'b1;
        end
        PH_LIT: begin
          r0_vld           = 1'b1;
          r0.command       = CMD_LITERAL;
          r0.literal_value = in_delta_byte;
          add_en           = 1'b1;
          if (lit_left_r != 7'd0) lit_left_nxt = lit_left_r - 7'd1;
          if (lit_left_nxt == 7'd0) phase_nxt = PH_OP;
        end
        default: ;
      endcase
    end

    // copy completion: size zero means 64 KiB, range check against base
    f_off  = goff_nxt;
    f_raw  = gsize_nxt;
    f_size = (f_raw == 24'd0) ? COPY_SIZE_ZERO : f_raw;
    f_end  = {1'b0, f_off} + {9'd0, f_size};
    if (do_finish) begin
      if (f_end > {11'd0, base_len_r}) begin
        err = ST_COPY_RANGE;
      end else begin
        r0_vld         = 1'b1;
        r0.command     = CMD_COPY;
        r0.copy_offset = f_off;
        r0.copy_length = f_size;
        add_en         = 1'b1;
        add_amt        = f_size;
        phase_nxt      = PH_OP;
      end
    end

    prod_sum = {3'd0, prod_r} + {1'b0, add_amt};
    prod_nxt = add_en ? prod_sum[LEN_W-1:0] : prod_r;
    over_nxt = over_r | (add_en & (|prod_sum[24:LEN_W]));

    src_eq  = !src_hi_nxt && (src_lo_nxt == base_len_r);
    tgt_big = tgt_hi_nxt || (tgt_lo_nxt > tgt_limit_r);

    if (!failed_r && (err == ST_OK) && in_final_byte) begin
      if ((phase_nxt == PH_SRC) && !src_eq) begin
        err = ST_SRC_MISMATCH;
      end else if (((phase_nxt == PH_SRC) || (phase_nxt == PH_DST)) && tgt_big) begin
        err = ST_TGT_BIG;
      end else if ((phase_nxt == PH_COPY) || (phase_nxt == PH_LIT)) begin
        err = ST_TRUNCATED;
      end else if (over_nxt || tgt_hi_nxt || (prod_nxt != tgt_lo_nxt)) begin
        err = ST_LEN_MISMATCH;
      end else begin
        r1_vld        = 1'b1;
        r1.command    = CMD_FINISHED;
        r1.end_of_run = 1'b1;
      end
    end

    if (err != ST_OK) begin
      r1_vld        = 1'b1;
      r1.command    = CMD_ERROR;
      r1.status     = err;
      r1.end_of_run = in_final_byte;
      if (!in_final_byte) begin
        failed_nxt = 1'b1;
        fstat_nxt  = err;
      end
    end

    if (in_final_byte) begin
      phase_nxt    = PH_SRC;
      src_lo_nxt   = '0;
      src_hi_nxt   = 1'b0;
      tgt_lo_nxt   = '0;
      tgt_hi_nxt   = 1'b0;
      vcnt_nxt     = '0;
      pend_nxt     = '0;
      goff_nxt     = '0;
      gsize_nxt    = '0;
      lit_left_nxt = '0;
      prod_nxt     = '0;
      over_nxt     = 1'b0;
      failed_nxt   = 1'b0;
      fstat_nxt    = ST_OK;
    end
  end

  // queue pointers
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = out_acc ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r - CNT_W'(out_acc);
    if (in_acc) begin
      if (r0_vld && r1_vld) wr_ptr_nxt = ptr_inc(ptr_inc(wr_ptr_r));
      else if (r0_vld || r1_vld) wr_ptr_nxt = ptr_inc(wr_ptr_r);
      count_nxt = count_nxt + CNT_W'(r0_vld) + CNT_W'(r1_vld);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (r0_vld) begin
        q_mem[wr_ptr_r] <= r0;
        if (r1_vld) q_mem[ptr_inc(wr_ptr_r)] <= r1;
      end else if (r1_vld) begin
        q_mem[wr_ptr_r] <= r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_len_r  <= '0;
      tgt_limit_r <= LIMIT_DEFAULT;
      phase_r     <= PH_SRC;
      src_lo_r    <= '0;
      src_hi_r    <= 1'b0;
      tgt_lo_r    <= '0;
      tgt_hi_r    <= 1'b0;
      vcnt_r      <= '0;
      pend_r      <= '0;
      goff_r      <= '0;
      gsize_r     <= '0;
      lit_left_r  <= '0;
      prod_r      <= '0;
      over_r      <= 1'b0;
      failed_r    <= 1'b0;
      fstat_r     <= ST_OK;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_LENGTH:  base_len_r  <= cfg_wdata;
          REG_TARGET_LIMIT: tgt_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r    <= phase_nxt;
        src_lo_r   <= src_lo_nxt;
        src_hi_r   <= src_hi_nxt;
        tgt_lo_r   <= tgt_lo_nxt;
        tgt_hi_r   <= tgt_hi_nxt;
        vcnt_r     <= vcnt_nxt;
        pend_r     <= pend_nxt;
        goff_r     <= goff_nxt;
        gsize_r    <= gsize_nxt;
        lit_left_r <= lit_left_nxt;
        prod_r     <= prod_nxt;
        over_r     <= over_nxt;
        failed_r   <= failed_nxt;
        fstat_r    <= fstat_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_command       = q_mem[rd_ptr_r].command;
  assign out_copy_offset   = q_mem[rd_ptr_r].copy_offset;
  assign out_copy_length   = q_mem[rd_ptr_r].copy_length;
  assign out_literal_value = q_mem[rd_ptr_r].literal_value;
  assign out_status        = q_mem[rd_ptr_r].status;
  assign out_end_of_run    = q_mem[rd_ptr_r].end_of_run;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_final_byte) |-> (r1_vld && r1.end_of_run))
    else $error("final byte without closing result");

  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_final_byte) |=> (phase_r == PH_SRC && !failed_r && prod_r == '0))
    else $error("stream state not cleared after final byte");
`endif

endmodule
